[rtl/oibs_pkg.sv]
// Package for the offset index binary search unit.
// Holds the item structs, request and status codes and the control states.
// No dependencies.
package oibs_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam int IDX_W = 12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] offset_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] unit_index;
        logic [1:0]       status;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

endpackage

[rtl/oibs_table.sv]
// Offset table storage: one write port and one registered read port.
// Entries are undefined until written. Uses no package items.
module oibs_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/offset_index_binary_search_unit.sv]
// Offset index binary search unit: top level with request control and search loop.
// Depends on oibs_pkg and oibs_table.
//
// One item is handled at a time. Clear, append and reserved requests need no
// search; the result sits in an output register, and the next item is taken as
// soon as that register is free or being emptied. A query on a loaded table
// makes one table read per search step, one step per cycle through the
// registered read port of the table memory: at most floor(log2(count)) + 1
// reads, so at most 13 reads at 4096 entries. The table needs no clearing pass:
// a clear resets the entry count only.
module offset_index_binary_search_unit #(
    parameter int DEPTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  oibs_pkg::in_item_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output oibs_pkg::out_item_t m_item
);
    import oibs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] first_reg, first_next;
    logic [CW-1:0] span_reg, span_next;
    logic [CW-1:0] probe_reg, probe_next;
    logic [63:0]   key_reg, key_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg, out_item_next;

    logic          s_fire;
    logic          table_full;
    logic          table_empty;
    logic          is_query;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    logic          step_hit;
    logic [CW-1:0] step_first;
    logic [CW-1:0] step_span;
    logic [CW-1:0] step_probe;
    logic          step_last;
    logic [31:0]   idx_wide;

    assign s_fire      = s_valid && s_ready;
    assign table_full  = (count_reg == CW'(DEPTH));
    assign table_empty = (count_reg == '0);
    assign is_query    = (s_item.req_type == REQ_QUERY);

    // one search step on the registered probe data
    assign step_hit   = !(key_reg < rd_data);
    assign step_first = step_hit ? (probe_reg + 1'b1) : first_reg;
    assign step_span  = step_hit ? (span_reg - (span_reg >> 1) - 1'b1) : (span_reg >> 1);
    assign step_probe = step_first + (step_span >> 1);
    assign step_last  = (step_span == '0);
    assign idx_wide   = (step_first == '0) ? 32'd0 : 32'(step_first - 1'b1);

    oibs_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_item.offset_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && is_query && !table_empty) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (step_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !out_valid_reg || m_ready;
                wr_en   = s_fire && (s_item.req_type == REQ_APPEND) && !table_full;
                rd_en   = s_fire && is_query && !table_empty;
                rd_addr = AW'(count_reg >> 1);
            end
            ST_SEARCH: begin
                rd_en   = !step_last;
                rd_addr = step_probe[AW-1:0];
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        first_next     = first_reg;
        span_next      = span_reg;
        probe_next     = probe_reg;
        key_next       = key_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    out_item_next.unit_index = '0;
                    out_item_next.status     = STATUS_DONE;
                    out_valid_next           = 1'b1;
                    case (s_item.req_type)
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        REQ_APPEND: begin
                            if (table_full) begin
                                out_item_next.status = STATUS_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            if (table_empty) begin
                                out_item_next.status = STATUS_EMPTY;
                            end else begin
                                out_valid_next = 1'b0;
                                first_next     = '0;
                                span_next      = count_reg;
                                probe_next     = count_reg >> 1;
                                key_next       = s_item.offset_value;
                            end
                        end
                        default: begin
                            out_item_next.status = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                first_next = step_first;
                span_next  = step_span;
                probe_next = step_probe;
                if (step_last) begin
                    out_item_next.unit_index = idx_wide[IDX_W-1:0];
                    out_item_next.status     = STATUS_DONE;
                    out_valid_next           = 1'b1;
                end
            end
            default: begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        span_reg     <= span_next;
        probe_reg    <= probe_next;
        key_reg      <= key_next;
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_search_span_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> span_reg != '0)
        else $error("search step with empty span");

    a_probe_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> probe_reg < count_reg)
        else $error("probe reads beyond loaded entries");

    a_no_result_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> !out_valid_reg && !s_ready)
        else $error("result or accept while searching");

    a_table_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |=> count_reg == $past(count_reg))
        else $error("entry count changed during search");

endmodule
